[hw/rtl/vt4x4_pkg.sv]
`default_nettype none

package vt4x4_pkg;

  localparam int WORD_W = 32;
  localparam int DIM    = 4;
  localparam int PROD_W = 2 * WORD_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = DIM * WORD_W;

  // Input word layout, lowest bit first
  localparam int ROW_LSB   = 0;
  localparam int COL_LSB   = 2;
  localparam int ENTRY_LSB = 4;
  localparam int POINT_LSB = 36;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  typedef logic signed [WORD_W-1:0] word_t;

  // Load enables for the four lane stages
  typedef struct packed {
    logic prod;
    logic pair;
    logic total;
    logic result;
  } stage_en_t;

endpackage : vt4x4_pkg

`default_nettype wire

[hw/rtl/vt4x4_lane.sv]
`default_nettype none

module vt4x4_lane
  import vt4x4_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic      clk,
  input  wire stage_en_t en,
  input  wire word_t     mrow  [DIM],
  input  wire word_t     point [DIM],
  output word_t          result
);

  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'(1) <<< (FRACTION_BITS - 1);

  logic signed [PROD_W-1:0] prod [DIM];
  logic signed [PAIR_W-1:0] pair [2];
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  biased;
  logic signed [SUM_W-1:0]  shifted;
  logic                     fits;
  word_t                    result_next;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      for (int j = 0; j < DIM; j++) begin
        prod[j] <= PROD_W'(mrow[j]) * PROD_W'(point[j]);
      end
    end
    if (en.pair) begin
      pair[0] <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair[1] <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
    if (en.total) begin
      total <= SUM_W'(pair[0]) + SUM_W'(pair[1]);
    end
    if (en.result) begin
      result <= result_next;
    end
  end

  // Round to nearest, ties up, then clamp to the signed word range
  always_comb begin
    biased  = total + BIAS;
    shifted = biased >>> FRACTION_BITS;
    fits    = (&shifted[SUM_W-1:WORD_W-1]) || !(|shifted[SUM_W-1:WORD_W-1]);
    if (fits) begin
      result_next = shifted[WORD_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      result_next = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      result_next = {1'b0, {(WORD_W-1){1'b1}}};
    end
  end

endmodule : vt4x4_lane

`default_nettype wire

[hw/rtl/vertex_transform_4x4_top.sv]
// 4x4 matrix times homogeneous point, signed fixed point with FRACTION_BITS
// fraction bits (Q16.16 by default).
// Input stream s_*: s_tuser is the op (0 loads one matrix entry, 1 transforms
// a point). A load writes the entry at its accept edge and gives no output
// word; every later transform sees it. A transform gives one output word on
// m_* holding the four rounded and saturated row dot products.
// Throughput: one word per cycle while m_tready keeps the output moving,
// loads and transforms mixed freely. A transform passes through four lane
// stages (products, pair sums, total, round and clamp) and then the output
// register. The four rows run in parallel lanes and the output register
// merges their results into one word.
// Back-pressure: each stage advances whenever the one after it is empty or
// moving, so bubbles close up while m_tready is low and s_tready falls only
// once every stage and the output register hold a result.
// Reset (rst, synchronous): pipeline emptied, matrix set to identity.
`default_nettype none

module vertex_transform_4x4_top
  import vt4x4_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // row[1:0], col[3:2], entry_value[35:4], point_x[67:36], point_y[99:68],
  // point_z[131:100], point_w[163:132], zero[167:164]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // op[0]
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam word_t ONE = WORD_W'(1) <<< FRACTION_BITS;

  word_t     matrix [DIM*DIM];
  word_t     point  [DIM];
  word_t     mrow   [DIM][DIM];
  word_t     lane_result [DIM];
  logic [3:0] widx;
  logic      s_acc;
  logic      v_prod, v_pair, v_total, v_result;
  logic      en_out;
  stage_en_t en;

  assign s_acc = s_tvalid && s_tready;
  assign widx  = {s_tdata[ROW_LSB +: 2], s_tdata[COL_LSB +: 2]};

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      point[j] = s_tdata[POINT_LSB + j*WORD_W +: WORD_W];
    end
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        mrow[i][j] = matrix[i*DIM + j];
      end
    end
  end

  // Stage advances when it is empty or the next one moves
  always_comb begin
    en_out    = !m_tvalid || m_tready;
    en.result = !v_result || en_out;
    en.total  = !v_total  || en.result;
    en.pair   = !v_pair   || en.total;
    en.prod   = !v_prod   || en.pair;
    s_tready  = en.prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIM*DIM; k++) begin
        matrix[k] <= (k % (DIM + 1) == 0) ? ONE : '0;
      end
    end else if (s_acc && s_tuser == OP_LOAD) begin
      matrix[widx] <= s_tdata[ENTRY_LSB +: WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_prod   <= 1'b0;
      v_pair   <= 1'b0;
      v_total  <= 1'b0;
      v_result <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en.prod)   v_prod   <= s_acc && s_tuser == OP_XFORM;
      if (en.pair)   v_pair   <= v_prod;
      if (en.total)  v_total  <= v_pair;
      if (en.result) v_result <= v_total;
      if (en_out)    m_tvalid <= v_result;
    end
  end

  // Merge the lane results into one output word
  always_ff @(posedge clk) begin
    if (en_out && v_result) begin
      for (int i = 0; i < DIM; i++) begin
        m_tdata[i*WORD_W +: WORD_W] <= lane_result[i];
      end
    end
  end

  for (genvar i = 0; i < DIM; i++) begin : g_lane
    vt4x4_lane #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .mrow  (mrow[i]),
      .point (point),
      .result(lane_result[i])
    );
  end

  a_load_writes: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tuser == OP_LOAD |=> matrix[$past(widx)] == $past(s_tdata[ENTRY_LSB +: WORD_W]))
    else $error("matrix entry not written by load");

  a_xform_enters: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> v_prod == $past(s_tuser == OP_XFORM))
    else $error("first stage valid does not follow accepted op");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    v_result && en_out |=> m_tvalid)
    else $error("finished result lost before output register");

  a_held_stage: assert property (@(posedge clk) disable iff (rst)
    v_total && !en.result |=> v_total && v_result)
    else $error("stalled stage dropped its result");

endmodule : vertex_transform_4x4_top

`default_nettype wire
